FILE: hw/rtl/tssc_pkg.sv
// Shared constants, types and helpers for the timing sample slot clusterer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tssc_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  localparam int DATA_W = 32;
  localparam int PCT_W  = 7;
  localparam int PROD_W = 2 * DATA_W;
  localparam int CMP_W  = 40;

  localparam logic [PCT_W-1:0]  MATCH_PCT_RESET = 7'd10;
  localparam logic [DATA_W:0]   PERCENT_SCALE   = 33'd100;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic [DATA_W-1:0] avg;
    logic [DATA_W-1:0] cnt;
  } slot_wr_t;

  // low three bits of a slot number, zero-extended when the index is narrower
  function automatic logic [2:0] idx_low3(logic [CNT_W-1:0] i);
    logic [CNT_W+2:0] ext;
    ext = {3'b000, i};
    return ext[2:0];
  endfunction

endpackage

FILE: hw/rtl/tssc_slot_table.sv
// Slot storage: running average and sample count per slot.
// Depends on tssc_pkg. One write port, one read port selected by the sequencer.
`timescale 1ns / 1ps

module tssc_slot_table (
  input  logic                      clk_i,
  input  tssc_pkg::slot_wr_t        wr_i,
  input  logic [tssc_pkg::SLOT_W-1:0] rd_idx_i,
  output logic [tssc_pkg::DATA_W-1:0] rd_avg_o,
  output logic [tssc_pkg::DATA_W-1:0] rd_cnt_o
);
  import tssc_pkg::*;

  logic [DATA_W-1:0] avg_mem [NUM_SLOTS];
  logic [DATA_W-1:0] cnt_mem [NUM_SLOTS];

  // contents are undefined until a slot is opened, so no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      avg_mem[wr_i.idx] <= wr_i.avg;
      cnt_mem[wr_i.idx] <= wr_i.cnt;
    end
  end

  assign rd_avg_o = avg_mem[rd_idx_i];
  assign rd_cnt_o = cnt_mem[rd_idx_i];

endmodule

FILE: hw/rtl/tssc_divider.sv
// Restoring divider, one quotient bit per cycle, for the slot average update.
// Depends on tssc_pkg. The quotient must fit in DATA_W bits.
`timescale 1ns / 1ps

module tssc_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tssc_pkg::PROD_W-1:0]  dividend_i,
  input  logic [tssc_pkg::DATA_W:0]    divisor_i,
  output logic [tssc_pkg::DATA_W-1:0]  quotient_o,
  output logic                         done_o
);
  import tssc_pkg::*;

  localparam int STEP_W = $clog2(DATA_W);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DATA_W:0]   rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W:0]   den_q, den_d;
  logic [DATA_W+1:0] trial;
  logic              fits;

  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      // the high word is already below the divisor, so only the low bits iterate
      run_d  = 1'b1;
      step_d = '0;
      rem_d  = {1'b0, dividend_i[PROD_W-1:DATA_W]};
      quo_d  = dividend_i[DATA_W-1:0];
      den_d  = divisor_i;
    end else if (run_q) begin
      if (fits) begin
        rem_d = (DATA_W + 1)'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[DATA_W:0];
      end
      quo_d  = {quo_q[DATA_W-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(DATA_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

FILE: hw/rtl/timing_sample_slot_clusterer_core.sv
// Timing sample slot clusterer: sequencer, shared multiplier and result registers.
// Depends on tssc_pkg, tssc_slot_table and tssc_divider.
// Sequence: each filled slot in turn is compared on the shared multiplier (scan, rhs and
//   compare states); a miss on all n filled slots opens slot n, or drops the request when the
//   table is full; the first match updates that slot with base*count, the add, then the divider.
// Throughput: one request at a time; busy stays high until the result strobe.
// Reset clears the fill count and restores match_percent to 10; slot contents are not cleared.
`timescale 1ns / 1ps

module timing_sample_slot_clusterer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tssc_pkg::PCT_W-1:0]  cfg_wdata_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [tssc_pkg::DATA_W-1:0] time_sample_i,
  output logic                        done_o,
  output logic [2:0]                  slot_index_o,
  output logic                        opened_new_o,
  output logic                        dropped_o,
  output logic [tssc_pkg::DATA_W-1:0] new_average_o,
  output logic [tssc_pkg::DATA_W-1:0] new_count_o
);
  import tssc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RHS  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_MULC = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [PCT_W-1:0]  pct_q;
  logic [CNT_W-1:0]  filled_q, filled_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [DATA_W-1:0] t_q, t_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [CMP_W-1:0]  lhs_q, lhs_d;

  logic              done_q, done_d;
  logic [2:0]        sidx_q, sidx_d;
  logic              open_q, open_d;
  logic              drop_q, drop_d;
  logic [DATA_W-1:0] navg_q, navg_d;
  logic [DATA_W-1:0] ncnt_q, ncnt_d;

  logic [DATA_W-1:0]   rd_avg, rd_cnt;
  logic [DATA_W-1:0]   diff;
  logic [DATA_W:0]     base;
  logic [DATA_W:0]     mul_a, mul_b;
  logic [2*DATA_W+1:0] mul_p;
  logic [DATA_W-1:0]   cnt_sat;
  logic                div_start, div_done;
  logic [PROD_W-1:0]   div_num;
  logic [DATA_W-1:0]   div_quo;
  slot_wr_t            wr;

  tssc_slot_table u_table (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .rd_idx_i (idx_q[SLOT_W-1:0]),
    .rd_avg_o (rd_avg),
    .rd_cnt_o (rd_cnt)
  );

  tssc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  ({1'b0, rd_cnt} + 1'b1),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  assign diff    = (t_q > rd_avg) ? (t_q - rd_avg) : (rd_avg - t_q);
  assign base    = (rd_avg == '0) ? (DATA_W + 1)'(1) : {1'b0, rd_avg};
  assign cnt_sat = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
  assign div_num = prod_q + {{(PROD_W - DATA_W){1'b0}}, t_q};

  // shared multiplier: diff*100, then percent*base, then base*count
  always_comb begin
    unique case (state_q)
      S_RHS: begin
        mul_a = {{(DATA_W + 1 - PCT_W){1'b0}}, pct_q};
        mul_b = base;
      end
      S_MULC: begin
        mul_a = base;
        mul_b = {1'b0, rd_cnt};
      end
      default: begin
        mul_a = {1'b0, diff};
        mul_b = PERCENT_SCALE;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_d   = state_q;
    filled_d  = filled_q;
    idx_d     = idx_q;
    t_d       = t_q;
    prod_d    = prod_q;
    lhs_d     = lhs_q;
    done_d    = 1'b0;
    sidx_d    = sidx_q;
    open_d    = open_q;
    drop_d    = drop_q;
    navg_d    = navg_q;
    ncnt_d    = ncnt_q;
    div_start = 1'b0;
    wr        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          t_d     = time_sample_i;
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_q == filled_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (filled_q != CNT_W'(NUM_SLOTS)) begin
            wr.en    = 1'b1;
            wr.idx   = filled_q[SLOT_W-1:0];
            wr.avg   = t_q;
            wr.cnt   = DATA_W'(1);
            filled_d = filled_q + 1'b1;
            sidx_d   = idx_low3(filled_q);
            open_d   = 1'b1;
            drop_d   = 1'b0;
            navg_d   = t_q;
            ncnt_d   = DATA_W'(1);
          end else begin
            sidx_d = '0;
            open_d = 1'b0;
            drop_d = 1'b1;
            navg_d = '0;
            ncnt_d = '0;
          end
        end else begin
          lhs_d   = mul_p[CMP_W-1:0];
          state_d = S_RHS;
        end
      end
      S_RHS: begin
        prod_d  = mul_p[PROD_W-1:0];
        state_d = S_CMP;
      end
      S_CMP: begin
        // floor(diff*100/base) < pct  <=>  diff*100 < pct*base
        if (lhs_q < prod_q[CMP_W-1:0]) begin
          state_d = S_MULC;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SCAN;
        end
      end
      S_MULC: begin
        prod_d  = mul_p[PROD_W-1:0];
        state_d = S_ADD;
      end
      S_ADD: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          wr.en   = 1'b1;
          wr.idx  = idx_q[SLOT_W-1:0];
          wr.avg  = div_quo;
          wr.cnt  = cnt_sat;
          done_d  = 1'b1;
          sidx_d  = idx_low3(idx_q);
          open_d  = 1'b0;
          drop_d  = 1'b0;
          navg_d  = div_quo;
          ncnt_d  = cnt_sat;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      filled_q <= '0;
      pct_q    <= MATCH_PCT_RESET;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      filled_q <= filled_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        pct_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    t_q    <= t_d;
    prod_q <= prod_d;
    lhs_q  <= lhs_d;
    sidx_q <= sidx_d;
    open_q <= open_d;
    drop_q <= drop_d;
    navg_q <= navg_d;
    ncnt_q <= ncnt_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign slot_index_o  = sidx_q;
  assign opened_new_o  = open_q;
  assign dropped_o     = drop_q;
  assign new_average_o = navg_q;
  assign new_count_o   = ncnt_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CNT_W'(NUM_SLOTS))
    else $error("fill count beyond table size");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && dropped_o |-> filled_q == CNT_W'(NUM_SLOTS) && !opened_new_o)
    else $error("request dropped while a slot was free");

  a_open_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_d && open_d |=> filled_q == $past(filled_q) + 1'b1)
    else $error("slot opened without advancing the fill count");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the update wait");

endmodule
